// ----- hw/rtl/smrc_pkg.sv -----
// Package for the multi-channel servo ramp controller.
// Holds item codes, mode codes, the channel entry type and reset constants.
// No dependencies.
package smrc_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] MODE_NORMAL      = 3'd0;
  localparam logic [2:0] MODE_RAMP_UP     = 3'd1;
  localparam logic [2:0] MODE_RAMP_DOWN   = 3'd2;
  localparam logic [2:0] MODE_DEAD_LOW    = 3'd3;
  localparam logic [2:0] MODE_ACTIVE_HIGH = 3'd4;
  localparam logic [2:0] MODE_NO_UPDATE   = 3'd5;

  localparam logic [7:0] STEP_RESET = 8'd5;

  localparam logic [2:0] REG_STEP_SIZE = 3'd0;

  typedef struct packed {
    logic [7:0] angle;
    logic [2:0] mode;
    logic       enable;
    logic [7:0] low;
    logic [7:0] high;
  } chan_entry_t;

  typedef struct packed {
    logic [7:0] angle;
    logic [2:0] mode;
    logic       changed;
  } tick_res_t;

  localparam chan_entry_t ENTRY_RESET = '{
    angle:  8'd0,
    mode:   MODE_NO_UPDATE,
    enable: 1'b0,
    low:    8'd0,
    high:   8'd0
  };

endpackage

// ----- hw/rtl/smrc_if.sv -----
// Request and result channel interfaces of the servo ramp controller.
// Valid/ready handshake; no dependencies.
interface smrc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] channel;
  logic [7:0] low_angle;
  logic [7:0] high_angle;
  logic [2:0] mode;
  logic       enable;

  modport source (output valid, kind, channel, low_angle, high_angle, mode, enable,
                  input ready);
  modport sink (input valid, kind, channel, low_angle, high_angle, mode, enable,
                output ready);
endinterface

interface smrc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic [7:0] angle;
  logic       last;

  modport source (output valid, out_channel, angle, last, input ready);
  modport sink (input valid, out_channel, angle, last, output ready);
endinterface

// ----- hw/rtl/multi_channel_servo_ramp_controller.sv -----
// Multi-channel servo ramp controller, top level. Channel state lives in one
// single-port-write memory that is read, updated and written back one channel
// per cycle while results are not held off. A tick request walks the memory
// one channel after another; an init or a set request reads its channel and
// then writes it back. Result back-pressure can stall a tick or an init.
// One result is held back until the next changed channel or the end of the
// walk, so that the final result of a tick carries the last mark.
// Depends on smrc_pkg, smrc_if, smrc_apb_regs, smrc_chan_mem, smrc_tick_alu.
module multi_channel_servo_ramp_controller #(
  parameter int CHANNELS = smrc_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smrc_req_if.sink    req_i,
  smrc_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import smrc_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SET,
    ST_TICK,
    ST_FLUSH
  } state_e;

  state_e      state_q;
  logic [7:0]  step;

  logic [AW-1:0] item_ch_q;
  logic [7:0]    item_lo_q;
  logic [7:0]    item_hi_q;
  logic [2:0]    item_mode_q;
  logic          item_en_q;

  logic [AW-1:0] idx_q;

  logic          pend_valid_q;
  logic [3:0]    pend_ch_q;
  logic [7:0]    pend_angle_q;

  logic          out_valid_q;
  logic [3:0]    out_ch_q;
  logic [7:0]    out_angle_q;
  logic          out_last_q;

  logic          accept;
  logic          chan_ok;
  logic          slot_free;
  logic          last_idx;
  logic          adv;
  logic          out_load;
  logic          re;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  chan_entry_t   wdata;
  chan_entry_t   ent;
  tick_res_t     tres;

  smrc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .step_o  (step)
  );

  smrc_chan_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (ent)
  );

  smrc_tick_alu u_alu (
    .entry_i (ent),
    .step_i  (step),
    .res_o   (tres)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign chan_ok     = (32'(req_i.channel) < CHANNELS);
  assign slot_free   = !out_valid_q || res_o.ready;
  assign last_idx    = (idx_q == AW'(CHANNELS - 1));
  assign adv         = !(tres.changed && pend_valid_q && !slot_free);
  assign out_load    = ((state_q == ST_INIT) && slot_free) ||
                       ((state_q == ST_TICK) && adv && tres.changed && pend_valid_q) ||
                       ((state_q == ST_FLUSH) && pend_valid_q && slot_free);

  always_comb begin
    re    = 1'b0;
    raddr = idx_q;
    we    = 1'b0;
    waddr = item_ch_q;
    wdata = ent;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_TICK) begin
            re    = 1'b1;
            raddr = '0;
          end else if ((req_i.kind == KIND_INIT || req_i.kind == KIND_SET) && chan_ok) begin
            re    = 1'b1;
            raddr = AW'(req_i.channel);
          end
        end
      end
      ST_INIT: begin
        we          = slot_free;
        wdata.angle = item_lo_q;
        wdata.mode  = MODE_NO_UPDATE;
        wdata.low   = item_lo_q;
        wdata.high  = item_hi_q;
      end
      ST_SET: begin
        we           = 1'b1;
        wdata.mode   = item_mode_q;
        wdata.enable = item_en_q;
      end
      ST_TICK: begin
        re          = 1'b1;
        raddr       = (!adv || last_idx) ? idx_q : idx_q + 1'b1;
        we          = adv;
        waddr       = idx_q;
        wdata.angle = tres.angle;
        wdata.mode  = tres.mode;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !res_o.ready);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_ch_q   <= AW'(req_i.channel);
            item_lo_q   <= req_i.low_angle;
            item_hi_q   <= req_i.high_angle;
            item_mode_q <= req_i.mode;
            item_en_q   <= req_i.enable;
            if (req_i.kind == KIND_TICK) begin
              idx_q   <= '0;
              state_q <= ST_TICK;
            end else if (req_i.kind == KIND_INIT && chan_ok) begin
              state_q <= ST_INIT;
            end else if (req_i.kind == KIND_SET && chan_ok) begin
              state_q <= ST_SET;
            end
          end
        end
        ST_INIT: begin
          if (slot_free) begin
            out_ch_q    <= 4'(item_ch_q);
            out_angle_q <= item_lo_q;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_SET: begin
          state_q <= ST_IDLE;
        end
        ST_TICK: begin
          if (adv) begin
            if (tres.changed) begin
              if (pend_valid_q) begin
                out_ch_q    <= pend_ch_q;
                out_angle_q <= pend_angle_q;
                out_last_q  <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_ch_q    <= 4'(idx_q);
              pend_angle_q <= tres.angle;
            end
            if (last_idx) begin
              state_q <= ST_FLUSH;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            out_ch_q     <= pend_ch_q;
            out_angle_q  <= pend_angle_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_channel = out_ch_q;
  assign res_o.angle       = out_angle_q;
  assign res_o.last        = out_last_q;

endmodule

// ----- hw/rtl/smrc_apb_regs.sv -----
// APB-style configuration register file holding the ramp step size.
// Depends on smrc_pkg.
module smrc_apb_regs (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  output logic [7:0] step_o
);
  import smrc_pkg::*;

  logic [7:0] step_q, step_d;
  logic       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_STEP_SIZE[2]);

  always_comb begin
    step_d = step_q;
    if (psel && penable && pwrite && hit) begin
      step_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else begin
      step_q <= step_d;
    end
  end

  assign prdata = hit ? {24'd0, step_q} : 32'd0;
  assign step_o = step_q;

endmodule

// ----- hw/rtl/smrc_chan_mem.sv -----
// Per-channel state memory with one write and one registered read port.
// Entries not yet written read as the reset entry. Depends on smrc_pkg.
module smrc_chan_mem #(
  parameter int CHANNELS = smrc_pkg::CHANNELS_DEF,
  parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  smrc_pkg::chan_entry_t wdata_i,
  output smrc_pkg::chan_entry_t rdata_o
);
  import smrc_pkg::*;

  chan_entry_t         mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  chan_entry_t         rdata_q;
  logic                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : ENTRY_RESET;

endmodule

// ----- hw/rtl/smrc_tick_alu.sv -----
// Per-channel tick update: normal, ramp, dead-low and active-high modes.
// Depends on smrc_pkg.
module smrc_tick_alu (
  input  smrc_pkg::chan_entry_t entry_i,
  input  logic [7:0]            step_i,
  output smrc_pkg::tick_res_t   res_o
);
  import smrc_pkg::*;

  logic [8:0] sum;
  logic [8:0] diff;
  logic       up_hit;
  logic       down_hit;
  logic [7:0] new_angle;
  logic [2:0] new_mode;

  assign sum      = {1'b0, entry_i.angle} + {1'b0, step_i};
  assign diff     = {1'b0, entry_i.angle} - {1'b0, step_i};
  assign up_hit   = (sum >= {1'b0, entry_i.high});
  assign down_hit = diff[8] || (diff[7:0] <= entry_i.low);

  always_comb begin
    new_angle = entry_i.angle;
    new_mode  = entry_i.mode;
    case (entry_i.mode)
      MODE_NORMAL: begin
        new_angle = entry_i.enable ? entry_i.high : entry_i.low;
        new_mode  = MODE_NO_UPDATE;
      end
      MODE_RAMP_UP, MODE_ACTIVE_HIGH: begin
        if (entry_i.enable) begin
          new_angle = up_hit ? entry_i.high : sum[7:0];
          if (up_hit && (entry_i.mode == MODE_RAMP_UP)) begin
            new_mode = MODE_RAMP_DOWN;
          end
        end
      end
      MODE_RAMP_DOWN, MODE_DEAD_LOW: begin
        if (entry_i.enable) begin
          new_angle = down_hit ? entry_i.low : diff[7:0];
          if (down_hit && (entry_i.mode == MODE_RAMP_DOWN)) begin
            new_mode = MODE_RAMP_UP;
          end
        end
      end
      default: begin
        new_angle = entry_i.angle;
      end
    endcase
  end

  assign res_o.angle   = new_angle;
  assign res_o.mode    = new_mode;
  assign res_o.changed = (new_angle != entry_i.angle);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the multi-channel servo ramp controller: directed and random
// requests, a per-channel angle predictor and an in-order check of angle writes.
// Depends on smrc_pkg, smrc_if and the controller top level.
module tb;
  import smrc_pkg::*;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [2:0] STEP_ADDR = 3'(REG_STEP_SIZE * 4);
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 30;
  localparam int SETTLE_CYCLES = 3 * (CHANNELS + 2);
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [7:0] low_angle;
    logic [7:0] high_angle;
    logic [2:0] mode;
    logic       enable;
  } servo_req_t;

  typedef struct packed {
    logic [3:0] out_channel;
    logic [7:0] angle;
    logic       last;
  } angle_write_t;

  class servo_bank_tracker;
    logic [7:0] angle_now [CHANNELS];
    logic [2:0] mode_now [CHANNELS];
    logic       enable_now [CHANNELS];
    logic [7:0] low_limit [CHANNELS];
    logic [7:0] high_limit [CHANNELS];
    logic [7:0] step;
    angle_write_t pending [$];
    int error_count;

    function new();
      step = STEP_RESET;
      error_count = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        angle_now[i] = 8'd0;
        mode_now[i] = MODE_NO_UPDATE;
        enable_now[i] = 1'b0;
        low_limit[i] = 8'd0;
        high_limit[i] = 8'd0;
      end
    endfunction

    function void set_step(logic [7:0] value);
      step = value;
    endfunction

    function void advance_channel(int i);
      int v;
      v = int'(angle_now[i]);
      case (mode_now[i])
        MODE_NORMAL: begin
          v = enable_now[i] ? int'(high_limit[i]) : int'(low_limit[i]);
          mode_now[i] = MODE_NO_UPDATE;
        end
        MODE_RAMP_UP, MODE_ACTIVE_HIGH: begin
          if (enable_now[i]) begin
            v = v + int'(step);
            if (v >= int'(high_limit[i])) begin
              v = int'(high_limit[i]);
              if (mode_now[i] == MODE_RAMP_UP) mode_now[i] = MODE_RAMP_DOWN;
            end
          end
        end
        MODE_RAMP_DOWN, MODE_DEAD_LOW: begin
          if (enable_now[i]) begin
            v = v - int'(step);
            if (v <= int'(low_limit[i])) begin
              v = int'(low_limit[i]);
              if (mode_now[i] == MODE_RAMP_DOWN) mode_now[i] = MODE_RAMP_UP;
            end
          end
        end
        default: ;
      endcase
      angle_now[i] = v[7:0];
    endfunction

    function void apply_request(servo_req_t r);
      angle_write_t batch [$];
      logic [7:0] prior;
      case (r.kind)
        KIND_INIT: begin
          if (r.channel < CHANNELS) begin
            low_limit[r.channel] = r.low_angle;
            high_limit[r.channel] = r.high_angle;
            angle_now[r.channel] = r.low_angle;
            mode_now[r.channel] = MODE_NO_UPDATE;
            pending.push_back('{out_channel: r.channel, angle: r.low_angle, last: 1'b1});
          end
        end
        KIND_SET: begin
          if (r.channel < CHANNELS) begin
            mode_now[r.channel] = r.mode;
            enable_now[r.channel] = r.enable;
          end
        end
        KIND_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            prior = angle_now[i];
            advance_channel(i);
            if (angle_now[i] != prior)
              batch.push_back('{out_channel: 4'(i), angle: angle_now[i], last: 1'b0});
          end
          if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
          foreach (batch[k]) pending.push_back(batch[k]);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("angle write field %s: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    function void check_angle_write(logic [3:0] ch, logic [7:0] ang, logic lst);
      angle_write_t want;
      if (pending.size() == 0) begin
        $error("angle write with none expected: channel %0d angle %0d", ch, ang);
        error_count++;
        return;
      end
      want = pending.pop_front();
      compare_field("out_channel", int'(want.out_channel), int'(ch));
      compare_field("angle", int'(want.angle), int'(ang));
      compare_field("last", int'(want.last), int'(lst));
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          stall_requests = 1'b0;
  bit          stall_results = 1'b0;
  bit          hold_results = 1'b0;
  int          cycle_count = 0;

  servo_bank_tracker tracker = new();

  smrc_req_if req_if ();
  smrc_res_if res_if ();

  multi_channel_servo_ramp_controller DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      tracker.check_angle_write(res_if.out_channel, res_if.angle, res_if.last);
  end

  function automatic int pick_gap(bit active);
    int roll;
    if (!active) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int stall_len;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_results = 1'b0;
      end else begin
        stall_len = pick_gap(stall_results);
        if (stall_len == 0) begin
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= 1'b0;
          repeat (stall_len - 1) @(negedge clk_i);
        end
      end
    end
  end

  function automatic servo_req_t blank_request();
    servo_req_t r;
    r.kind = 2'($urandom);
    r.channel = 4'($urandom);
    r.low_angle = 8'($urandom);
    r.high_angle = 8'($urandom);
    r.mode = 3'($urandom);
    r.enable = 1'($urandom);
    return r;
  endfunction

  function automatic servo_req_t random_request();
    servo_req_t r;
    int roll;
    logic [7:0] a;
    logic [7:0] b;
    r = blank_request();
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      r.kind = KIND_UNUSED;
    end else if (roll < 22) begin
      r.kind = KIND_INIT;
      if ($urandom_range(0, 6) != 0) begin
        a = 8'($urandom_range(0, 180));
        b = 8'($urandom_range(0, 180));
        r.low_angle = (a < b) ? a : b;
        r.high_angle = (a < b) ? b : a;
      end
    end else if (roll < 52) begin
      r.kind = KIND_SET;
      if ($urandom_range(0, 6) != 0) begin
        r.mode = 3'($urandom_range(MODE_NORMAL, MODE_ACTIVE_HIGH));
        r.enable = ($urandom_range(0, 4) != 0);
      end
    end else begin
      r.kind = KIND_TICK;
    end
    return r;
  endfunction

  task automatic offer_request(input servo_req_t r);
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.kind <= r.kind;
    req_if.channel <= r.channel;
    req_if.low_angle <= r.low_angle;
    req_if.high_angle <= r.high_angle;
    req_if.mode <= r.mode;
    req_if.enable <= r.enable;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.apply_request(r);
  endtask

  task automatic pause_requests(input int n);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic init_channel(input logic [3:0] ch, input logic [7:0] lo,
                              input logic [7:0] hi);
    servo_req_t r;
    r = blank_request();
    r.kind = KIND_INIT;
    r.channel = ch;
    r.low_angle = lo;
    r.high_angle = hi;
    offer_request(r);
  endtask

  task automatic set_channel(input logic [3:0] ch, input logic [2:0] md, input logic en);
    servo_req_t r;
    r = blank_request();
    r.kind = KIND_SET;
    r.channel = ch;
    r.mode = md;
    r.enable = en;
    offer_request(r);
  endtask

  task automatic send_kind(input logic [1:0] k);
    servo_req_t r;
    r = blank_request();
    r.kind = k;
    offer_request(r);
  endtask

  task automatic drain_and_settle();
    pause_requests(1);
    while (tracker.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STEP_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_step(value[7:0]);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    servo_req_t r;
    int sent;
    logic [31:0] step_value;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_INIT;
    req_if.channel = '0;
    req_if.low_angle = '0;
    req_if.high_angle = '0;
    req_if.mode = MODE_NO_UPDATE;
    req_if.enable = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset step size.
    send_kind(KIND_TICK);
    init_channel(4'd0, 8'd0, 8'd180);
    init_channel(4'd15, 8'd10, 8'd170);
    set_channel(4'd0, MODE_RAMP_UP, 1'b1);
    set_channel(4'd15, MODE_NORMAL, 1'b1);
    init_channel(4'd1, 8'd200, 8'd30);
    set_channel(4'd1, MODE_ACTIVE_HIGH, 1'b1);
    init_channel(4'd2, 8'd40, 8'd255);
    set_channel(4'd2, MODE_DEAD_LOW, 1'b1);
    set_channel(4'd3, MODE_SPARE_LO, 1'b1);
    init_channel(4'd4, 8'd90, 8'd100);
    set_channel(4'd4, MODE_RAMP_DOWN, 1'b0);
    set_channel(4'd5, MODE_NORMAL, 1'b0);
    send_kind(KIND_UNUSED);
    send_kind(KIND_TICK);
    set_channel(4'd4, MODE_RAMP_DOWN, 1'b1);
    set_channel(4'd6, MODE_SPARE_HI, 1'b0);
    set_channel(4'd7, MODE_NO_UPDATE, 1'b1);
    send_kind(KIND_TICK);
    init_channel(4'd8, 8'd255, 8'd0);
    set_channel(4'd8, MODE_RAMP_UP, 1'b1);
    send_kind(KIND_TICK);
    send_kind(KIND_TICK);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p)
        0: step_value = 32'd1;
        1: step_value = 32'd180;
        2: step_value = 32'd0;
        3: step_value = 32'd255;
        default: step_value = ($urandom() & 32'hFFFF_FF00) | $urandom_range(1, 180);
      endcase
      write_step(step_value);
      stall_requests = (p != 0) && (p != 3);
      stall_results = (p != 0);
      if (p == 2) hold_results = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = random_request();
        offer_request(r);
        if (r.kind != KIND_UNUSED) sent++;
        pause_requests(pick_gap(stall_requests));
      end
    end

    drain_and_settle();
    if (tracker.error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
